FILE: sv/hsn_pkg.sv
// ============================================================================
// hsn_pkg
// Shared types and constants for the HTML strip and newline normalizer.
// ============================================================================
package hsn_pkg;

    // Largest number of results a single input byte may produce.
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Depth of the command queue between classifier and expander.
    localparam int CMDQ_DEPTH  = 4;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_BREAK = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Characters of interest.
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_NUL  = 8'h00;

    // Entity tracking: idle, matching "nbsp;" (one past the matched count),
    // and skipping up to the closing semicolon.
    localparam int         ENT_W     = 3;
    localparam logic [2:0] ENT_IDLE  = 3'd0;
    localparam logic [2:0] ENT_FIRST = 3'd1;
    localparam logic [2:0] ENT_FINAL = 3'd5;
    localparam logic [2:0] ENT_SKIP  = 3'd6;

    // Expected character of the "nbsp;" match at a given matching phase.
    function automatic logic [7:0] nbsp_char(input logic [2:0] phase);
        logic [7:0] ch;
        unique case (phase)
            3'd1:    ch = 8'h6E; // n
            3'd2:    ch = 8'h62; // b
            3'd3:    ch = 8'h73; // s
            3'd4:    ch = 8'h70; // p
            3'd5:    ch = CH_SEMI;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // One queued command: a character (or marker) repeated cnt times.
    typedef struct packed {
        logic [7:0]       ch;
        logic [1:0]       kind;
        logic [CNT_W-1:0] cnt;
        logic             last;
    } t_cmd;

endpackage

FILE: sv/hsn_front.sv
// ============================================================================
// hsn_front
// Classifies each input byte: tag and entity stripping, line-break folding,
// and tab sizing. Produces at most one command per accepted byte.
// ============================================================================
module hsn_front
    import hsn_pkg::*;
#(
    parameter int TAB_SPACES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_accept,
    input  logic [7:0] i_in_char,
    input  logic       i_is_last,
    output logic       o_cmd_push,
    output t_cmd       o_cmd
);

    localparam int TAB_CNT = (TAB_SPACES < MAX_RESULTS) ? TAB_SPACES : MAX_RESULTS;

    typedef enum logic [1:0] {
        BRK_NONE,
        BRK_CR,
        BRK_CRCR
    } t_brk;

    logic             r_html_mode;
    logic             r_tag_open;
    logic [ENT_W-1:0] r_ent;
    t_brk             r_brk;

    logic             n_tag_open;
    logic [ENT_W-1:0] n_ent;
    t_brk             n_brk;

    logic             w_have;
    logic [7:0]       w_y;
    t_cmd             w_cmd;

    always_comb begin
        n_tag_open = r_tag_open;
        n_ent      = r_ent;
        n_brk      = r_brk;
        w_have     = 1'b0;
        w_y        = i_in_char;

        if (r_html_mode) begin
            priority if (r_ent >= ENT_FIRST && r_ent <= ENT_FINAL) begin
                if (i_in_char == nbsp_char(r_ent)) begin
                    if (r_ent == ENT_FINAL) begin
                        n_ent  = ENT_IDLE;
                        w_have = 1'b1;
                        w_y    = CH_SP;
                    end else begin
                        n_ent = r_ent + 3'd1;
                    end
                end else if (i_in_char == CH_SEMI) begin
                    n_ent = ENT_IDLE;
                end else begin
                    n_ent = ENT_SKIP;
                end
            end else if (r_ent >= ENT_SKIP) begin
                // Unknown entity: drop everything up to the semicolon.
                if (i_in_char == CH_SEMI) begin
                    n_ent = ENT_IDLE;
                end
            end else if (i_in_char == CH_LT) begin
                n_tag_open = 1'b1;
            end else if (r_tag_open && i_in_char == CH_GT) begin
                n_tag_open = 1'b0;
            end else if (i_in_char == CH_AMP) begin
                n_ent = ENT_FIRST;
            end else if (!r_tag_open) begin
                w_have = 1'b1;
            end else begin
                // Plain bytes inside a tag are dropped.
                w_have = 1'b0;
            end
        end else begin
            w_have = 1'b1;
        end

        w_cmd.ch   = CH_NUL;
        w_cmd.kind = KIND_CHAR;
        w_cmd.cnt  = '0;
        w_cmd.last = 1'b0;

        if (w_have) begin
            priority if (w_y == CH_CR) begin
                if (r_brk == BRK_CR) begin
                    n_brk = BRK_CRCR;
                end else begin
                    w_cmd.kind = KIND_BREAK;
                    w_cmd.cnt  = CNT_W'(1);
                    n_brk      = BRK_CR;
                end
            end else if (w_y == CH_LF) begin
                if (r_brk == BRK_NONE) begin
                    w_cmd.kind = KIND_BREAK;
                    w_cmd.cnt  = CNT_W'(1);
                end
                n_brk = BRK_NONE;
            end else begin
                n_brk = BRK_NONE;
                if (w_y == CH_TAB) begin
                    w_cmd.ch  = CH_SP;
                    w_cmd.cnt = CNT_W'(TAB_CNT);
                end else begin
                    w_cmd.ch  = w_y;
                    w_cmd.cnt = CNT_W'(1);
                end
            end
        end

        // The last byte always yields at least one result and restarts the text.
        if (i_is_last) begin
            if (w_cmd.cnt == '0) begin
                w_cmd.ch   = CH_NUL;
                w_cmd.kind = KIND_END;
                w_cmd.cnt  = CNT_W'(1);
            end
            w_cmd.last = 1'b1;
            n_tag_open = 1'b0;
            n_ent      = ENT_IDLE;
            n_brk      = BRK_NONE;
        end
    end

    assign o_cmd_push = i_accept && (w_cmd.cnt != '0);
    assign o_cmd      = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_html_mode <= 1'b0;
            r_tag_open  <= 1'b0;
            r_ent       <= ENT_IDLE;
            r_brk       <= BRK_NONE;
        end else begin
            if (i_cfg_we) begin
                r_html_mode <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_tag_open <= n_tag_open;
                r_ent      <= n_ent;
                r_brk      <= n_brk;
            end
        end
    end

    a_ent_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ent <= ENT_SKIP)
        else $error("entity phase out of range");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_is_last) |=>
            (!r_tag_open && r_ent == ENT_IDLE && r_brk == BRK_NONE))
        else $error("state not cleared after the last byte");

    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_is_last) |-> (o_cmd_push && o_cmd.last))
        else $error("last byte produced no terminating command");

endmodule

FILE: sv/hsn_fifo.sv
// ============================================================================
// hsn_fifo
// Short command queue that decouples the classifier from the expander.
// ============================================================================
module hsn_fifo
    import hsn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    input  logic i_rd,
    output t_cmd o_rdata,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CNT_W2 = $clog2(CMDQ_DEPTH + 1);

    t_cmd              r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [CNT_W2-1:0] r_count;

    assign o_rdata = r_mem[r_rptr];
    assign o_full  = (r_count == CNT_W2'(CMDQ_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (i_rd) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + CNT_W2'(1);
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - CNT_W2'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && o_empty))
        else $error("command queue underflow");

endmodule

FILE: sv/hsn_back.sv
// ============================================================================
// hsn_back
// Expands queued commands into result beats and holds the output register.
// ============================================================================
module hsn_back
    import hsn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_q_head,
    output logic       o_q_rd,
    input  logic       i_pop,
    output logic       o_empty,
    output logic [7:0] o_out_char,
    output logic [1:0] o_kind,
    output logic       o_last
);

    // r_rem counts the beats of the current command still to be delivered,
    // including the one on the output.
    logic [CNT_W-1:0] r_rem;
    logic [7:0]       r_ch;
    logic [1:0]       r_kind;
    logic             r_last;

    logic w_advance;
    logic w_reload;

    assign w_advance = (r_rem == '0) || i_pop;
    assign w_reload  = w_advance && (r_rem <= CNT_W'(1));
    assign o_q_rd    = w_reload && !i_q_empty;

    assign o_empty    = (r_rem == '0);
    assign o_out_char = r_ch;
    assign o_kind     = r_kind;
    assign o_last     = r_last && (r_rem == CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (w_advance) begin
            if (!w_reload) begin
                r_rem <= r_rem - CNT_W'(1);
            end else if (!i_q_empty) begin
                r_rem  <= i_q_head.cnt;
                r_ch   <= i_q_head.ch;
                r_kind <= i_q_head.kind;
                r_last <= i_q_head.last;
            end else begin
                r_rem <= '0;
            end
        end
    end

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= CNT_W'(MAX_RESULTS))
        else $error("repeat count out of range");

    a_end_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && r_kind == KIND_END) |-> (r_rem == CNT_W'(1) && o_last))
        else $error("end marker must be a single final beat");

endmodule

FILE: sv/html_strip_newline_normalizer_unit.sv
// ============================================================================
// html_strip_newline_normalizer_unit
// HTML tag/entity stripper with newline folding and tab expansion.
// ============================================================================
// Usage:
//   Input bytes enter on push/full: a beat is taken at a clock edge with
//   push high and full low, carrying i_in_char and i_is_last.
//   Results leave on empty/pop: while empty is low the oldest result sits on
//   o_out_char, o_kind and o_last, and it is taken at an edge with pop high.
//   The html_mode register is written through i_cfg_we / i_cfg_wdata; the user
//   must write it only while the block is idle, which the block does not enforce.
// Flow and throughput:
//   An accepted byte's command is written into the command queue, then loaded
//   into the output register when the output side is free. One byte enters per
//   cycle while pop is high and each yields at most one result; the expander
//   gives a tab TAB_SPACES beats (at most eight), one per cycle while pop is high.
// Stalls: a four-entry command queue sits between the classifier and the
//   expander; when pop is held low the queue fills and full rises.
// Reset: synchronous, active low; clears html_mode and the tag, entity and
//   line-break state, and empties the queue and the output register.
// ============================================================================
module html_strip_newline_normalizer_unit
    import hsn_pkg::*;
#(
    parameter int TAB_SPACES = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_char,
    input  logic       i_is_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_char,
    output logic [1:0] o_kind,
    output logic       o_last
);

    logic w_accept;
    logic w_cmd_push;
    t_cmd w_cmd;
    logic w_q_rd;
    t_cmd w_q_head;
    logic w_q_full;
    logic w_q_empty;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    hsn_front #(
        .TAB_SPACES (TAB_SPACES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_in_char   (i_in_char),
        .i_is_last   (i_is_last),
        .o_cmd_push  (w_cmd_push),
        .o_cmd       (w_cmd)
    );

    hsn_fifo u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_cmd_push),
        .i_wdata (w_cmd),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_head),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    hsn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_q_head   (w_q_head),
        .o_q_rd     (w_q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_out_char (o_out_char),
        .o_kind     (o_kind),
        .o_last     (o_last)
    );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the HTML strip and newline normalizer.
// Plain and HTML text is pushed through the queue-style input while a
// scoreboard predicts every result beat. Popped beats are compared in order,
// with random stalls on both sides and one long receiver hold-off.
// ============================================================================
module tb;
    import hsn_pkg::*;

    localparam int          TAB_SPACES  = 8;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          SETTLE      = 12;
    localparam logic [39:0] NBSP_WORD   = "nbsp;";

    typedef enum logic [1:0] {BRK_TEXT, BRK_AFTER_CR, BRK_AFTER_CRCR} t_brk;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] kind;
        logic       last;
    } t_beat;

    // Byte i (0 = 'n') of the nbsp entity body.
    function automatic logic [7:0] nbsp_byte(input int i);
        return NBSP_WORD[39 - 8 * i -: 8];
    endfunction

    class strip_scoreboard;
        bit         html_mode;
        bit         tag_open;
        logic [2:0] ent_phase;
        t_brk       brk_phase;
        t_beat      beats_due[$];
        int         errors;

        function new();
            html_mode = 1'b0;
            errors    = 0;
            clear_text();
        endfunction

        function void clear_text();
            tag_open  = 1'b0;
            ent_phase = ENT_IDLE;
            brk_phase = BRK_TEXT;
        endfunction

        function t_beat mk(input logic [7:0] ch, input logic [1:0] kind);
            t_beat b;
            b.ch   = ch;
            b.kind = kind;
            b.last = 1'b0;
            return b;
        endfunction

        function void note_error(input string msg);
            errors++;
            if (errors <= 10) begin
                $display("%s", msg);
            end
        endfunction

        // Works out the beats that one accepted byte produces.
        function void normalize_byte(input logic [7:0] ch, input logic lst);
            logic       have;
            logic [7:0] y;
            t_beat      made[$];
            t_beat      b;
            have = 1'b0;
            y    = CH_NUL;
            if (html_mode) begin
                if (ent_phase >= ENT_FIRST && ent_phase <= ENT_FINAL) begin
                    if (ch == nbsp_byte(int'(ent_phase) - 1)) begin
                        if (ent_phase == ENT_FINAL) begin
                            ent_phase = ENT_IDLE;
                            have      = 1'b1;
                            y         = CH_SP;
                        end else begin
                            ent_phase = ent_phase + 3'd1;
                        end
                    end else if (ch == CH_SEMI) begin
                        ent_phase = ENT_IDLE;
                    end else begin
                        ent_phase = ENT_SKIP;
                    end
                end else if (ent_phase >= ENT_SKIP) begin
                    if (ch == CH_SEMI) begin
                        ent_phase = ENT_IDLE;
                    end
                end else if (ch == CH_LT) begin
                    tag_open = 1'b1;
                end else if (tag_open && ch == CH_GT) begin
                    tag_open = 1'b0;
                end else if (ch == CH_AMP) begin
                    ent_phase = ENT_FIRST;
                end else if (!tag_open) begin
                    have = 1'b1;
                    y    = ch;
                end
            end else begin
                have = 1'b1;
                y    = ch;
            end

            if (have) begin
                if (y == CH_CR) begin
                    if (brk_phase == BRK_AFTER_CR) begin
                        brk_phase = BRK_AFTER_CRCR;
                    end else begin
                        made.push_back(mk(CH_NUL, KIND_BREAK));
                        brk_phase = BRK_AFTER_CR;
                    end
                end else if (y == CH_LF) begin
                    // An LF right after one or two CRs is part of that break.
                    if (brk_phase == BRK_TEXT) begin
                        made.push_back(mk(CH_NUL, KIND_BREAK));
                    end
                    brk_phase = BRK_TEXT;
                end else begin
                    brk_phase = BRK_TEXT;
                    if (y == CH_TAB) begin
                        for (int i = 0; i < TAB_SPACES && i < MAX_RESULTS; i++) begin
                            made.push_back(mk(CH_SP, KIND_CHAR));
                        end
                    end else begin
                        made.push_back(mk(y, KIND_CHAR));
                    end
                end
            end

            if (lst && made.size() == 0) begin
                made.push_back(mk(CH_NUL, KIND_END));
            end
            foreach (made[i]) begin
                b      = made[i];
                b.last = lst && (i == made.size() - 1);
                beats_due.push_back(b);
            end
            if (lst) begin
                clear_text();
            end
        endfunction

        function void check_beat(input logic [7:0] ch, input logic [1:0] kind,
                                 input logic last);
            t_beat want;
            if (beats_due.size() == 0) begin
                note_error($sformatf("unexpected beat: char %02h kind %0d last %0b",
                                     ch, kind, last));
                return;
            end
            want = beats_due.pop_front();
            if (want.ch !== ch || want.kind !== kind || want.last !== last) begin
                note_error($sformatf({"mismatch: expected char %02h kind %0d last %0b,",
                                      " got char %02h kind %0d last %0b"},
                                     want.ch, want.kind, want.last, ch, kind, last));
            end
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       push      = 1'b0;
    logic       full;
    logic [7:0] in_char   = 8'h00;
    logic       is_last   = 1'b0;
    logic       empty;
    logic       pop       = 1'b0;
    logic [7:0] out_char;
    logic [1:0] kind;
    logic       out_last;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_left    = 0;
    int cycles       = 0;

    strip_scoreboard sb = new();

    html_strip_newline_normalizer_unit #(
        .TAB_SPACES(TAB_SPACES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .push       (push),
        .full       (full),
        .i_in_char  (in_char),
        .i_is_last  (is_last),
        .empty      (empty),
        .pop        (pop),
        .o_out_char (out_char),
        .o_kind     (kind),
        .o_last     (out_last)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("html_strip_newline_normalizer_unit verification failed");
            $finish;
        end
    end

    // Both handshakes and register writes are observed at the rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            if (pop && !empty) begin
                sb.check_beat(out_char, kind, out_last);
            end
            if (push && !full) begin
                sb.normalize_byte(in_char, is_last);
            end
            if (cfg_we) begin
                sb.html_mode = cfg_wdata;
            end
        end
    end

    // Receiver: random pop, or a counted hold-off when one is requested.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Enters and leaves at a falling edge; push stays high for a following beat.
    task automatic send_byte(input logic [7:0] ch, input logic lst);
        while ($urandom_range(99) < snd_idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push    <= 1'b1;
        in_char <= ch;
        is_last <= lst;
        do @(posedge clk); while (full);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (sb.beats_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_mode(input logic mode);
        push <= 1'b0;
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_text(input logic [7:0] txt[$]);
        foreach (txt[i]) begin
            send_byte(txt[i], i == txt.size() - 1);
        end
    endtask

    // Random text built from short fragments: breaks, tabs, tags, entities,
    // printable runs and raw bytes, with an occasional end of text anywhere.
    task automatic run_random(input int count);
        logic [7:0] frag[$];
        int         sent;
        int         k;
        sent = 0;
        while (sent < count) begin
            frag.delete();
            case ($urandom_range(9))
                0, 1: frag.push_back(8'($urandom_range(255)));
                2: begin
                    k = $urandom_range(5);
                    if (k == 1) begin
                        frag.push_back(CH_LF);
                    end else begin
                        frag.push_back(CH_CR);
                        if (k >= 3) frag.push_back(CH_CR);
                        if (k == 2 || k == 4) frag.push_back(CH_LF);
                        if (k == 5) frag.push_back(CH_CR);
                    end
                end
                3: frag.push_back(CH_TAB);
                4, 5: begin
                    frag.push_back(CH_LT);
                    k = $urandom_range(4);
                    repeat (k) begin
                        if ($urandom_range(3) == 0) begin
                            frag.push_back(8'($urandom_range(255)));
                        end else begin
                            frag.push_back(8'($urandom_range(8'h7A, 8'h61)));
                        end
                    end
                    frag.push_back(CH_GT);
                end
                6, 7: begin
                    frag.push_back(CH_AMP);
                    k = $urandom_range(8);
                    if (k >= 5) begin
                        for (int i = 0; i < 5; i++) frag.push_back(nbsp_byte(i));
                    end else begin
                        for (int i = 0; i < k; i++) frag.push_back(nbsp_byte(i));
                        if ($urandom_range(1)) frag.push_back(8'($urandom_range(255)));
                        frag.push_back(CH_SEMI);
                    end
                end
                default: begin
                    k = $urandom_range(4, 1);
                    repeat (k) frag.push_back(8'($urandom_range(8'h7E, 8'h20)));
                end
            endcase
            foreach (frag[i]) begin
                send_byte(frag[i], $urandom_range(99) < 4);
            end
            sent += frag.size();
        end
    endtask

    initial begin
        logic [7:0] plain_txt[$];
        logic [7:0] html_txt[$];

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Plain text: byte extremes, tab, CR CR LF, lone LF, lone CR.
        plain_txt = '{CH_NUL, 8'hFF, CH_TAB, CH_CR, CH_CR, CH_LF, CH_LF, CH_CR, 8'h41};
        // HTML: nbsp inside a tag, '>' outside a tag, a short entity, an
        // entity holding '<', and a text that ends inside an open tag.
        html_txt  = '{CH_LT, 8'h61, CH_AMP, 8'h6E, 8'h62, 8'h73, 8'h70, CH_SEMI, CH_GT,
                      CH_GT, CH_AMP, 8'h6E, CH_SEMI, CH_AMP, 8'h78, CH_LT, CH_SEMI,
                      CH_LT, CH_LT};

        set_mode(1'b0);
        send_text(plain_txt);
        set_mode(1'b1);
        send_text(html_txt);

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 46 : 0;
            rcv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 9 : 0;
            set_mode(1'b1);
            if (ph == 0) begin
                // Long receiver stall so the queue fills and full rises.
                hold_left = 250;
            end
            run_random(50);
            set_mode(1'b0);
            run_random(25);
        end

        push <= 1'b0;
        wait_drained();
        if (sb.errors == 0 && sb.beats_due.size() == 0) begin
            $display("html_strip_newline_normalizer_unit verification clean");
        end else begin
            $display("html_strip_newline_normalizer_unit verification failed");
        end
        $finish;
    end

endmodule
